>>> hdl/pbcs_pkg.sv
package pbcs_pkg;

    localparam logic [1:0] CMD_CFG_RD = 2'd0;
    localparam logic [1:0] CMD_CFG_WR = 2'd1;
    localparam logic [1:0] CMD_IO_RD  = 2'd2;
    localparam logic [1:0] CMD_IO_WR  = 2'd3;

    localparam logic [7:0]  SMI_EN_REG   = 8'hA2;
    localparam logic [7:0]  SMI_REQ_REG  = 8'hAA;
    localparam logic [15:0] APM_CTL_PORT = 16'h00B2;
    localparam logic [15:0] APM_STS_PORT = 16'h00B3;
    localparam logic [7:0]  ABSENT_BYTE  = 8'hFF;

    localparam logic [7:0] REG_COMMAND_LO = 8'h04;
    localparam logic [7:0] REG_COMMAND_HI = 8'h05;
    localparam logic [7:0] REG_STATUS_LO  = 8'h06;
    localparam logic [7:0] REG_STATUS_HI  = 8'h07;
    localparam logic [7:0] REG_ROUTE_A    = 8'h60;
    localparam logic [7:0] REG_ROUTE_C    = 8'h61;
    localparam logic [7:0] REG_ROUTE_B    = 8'h62;
    localparam logic [7:0] REG_ROUTE_D    = 8'h63;
    localparam logic [7:0] REG_SMI_REQ_HI = 8'hAB;

    localparam logic [1:0] PIN_INTA = 2'd0;
    localparam logic [1:0] PIN_INTB = 2'd1;
    localparam logic [1:0] PIN_INTC = 2'd2;
    localparam logic [1:0] PIN_INTD = 2'd3;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_SMI_LOOK,
        ST_SMI_EXEC
    } state_t;

    typedef enum logic
    {
        RSEL_ITEM,
        RSEL_SMI_REQ
    } rd_sel_t;

    typedef struct packed
    {
        logic    capture;
        rd_sel_t rd_sel;
        logic    exec;
        logic    smi_exec;
    } dp_cmd_t;

    typedef struct packed
    {
        logic smi_go;
    } dp_sts_t;

    function automatic logic [7:0] reset_value(input logic [7:0] a);
        logic [7:0] v;
        case (a)
            8'h00: v = 8'h86;
            8'h01: v = 8'h80;
            8'h02: v = 8'h84;
            8'h03: v = 8'h04;
            8'h04: v = 8'h07;
            8'h07: v = 8'h02;
            8'h08: v = 8'h03;
            8'h40: v = 8'h20;
            8'h42: v = 8'h04;
            8'h44: v = 8'h20;
            8'h45: v = 8'h10;
            8'h46: v = 8'h0F;
            8'h48: v = 8'h01;
            8'h49: v = 8'h10;
            8'h4A: v = 8'h10;
            8'h4B: v = 8'h0F;
            8'h4C: v = 8'h56;
            8'h4D: v = 8'h40;
            8'h4E: v = 8'h07;
            8'h4F: v = 8'h4F;
            8'h60: v = 8'h80;
            8'h61: v = 8'h80;
            8'h62: v = 8'h80;
            8'h63: v = 8'h80;
            8'h80: v = 8'h78;
            8'hA0: v = 8'h08;
            8'hA8: v = 8'h0F;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic is_read_only(input logic [7:0] a);
        logic ro;
        ro = (a >= 8'h0F && a < 8'h4C) || (a <= 8'h03)
             || (a >= 8'h08 && a <= 8'h0B) || (a == 8'h0E);
        return ro;
    endfunction

endpackage

>>> hdl/pci_bridge_config_space_apm_smi.sv
// channel   handshake        payload
// item in   start / busy     cmd, func_num, reg_addr, io_port, wr_data
// result    done (1 cycle)   rd_data, smi_pulse, route_valid, route_pin, route_off, route_irq
//
// an item passes capture, config memory read and execute; an apm control
// write with smi enabled adds a read and a write for the read-modify-write of the smi request byte
// the result strobe comes the cycle after the last execute step, when a new item can already be taken
// rst_n clears control state, apm registers and the per-byte valid bits; unwritten
// config bytes read as their reset values, so no clearing pass is needed
// the receiver cannot stall; each result is shown for exactly one cycle
module pci_bridge_config_space_apm_smi
    import pbcs_pkg::*;
#(
    parameter int CFG_SIZE = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [2:0]  func_num,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] io_port,
    input  logic [7:0]  wr_data,
    output logic        done,
    output logic [7:0]  rd_data,
    output logic        smi_pulse,
    output logic        route_valid,
    output logic [1:0]  route_pin,
    output logic        route_off,
    output logic [3:0]  route_irq
);

    dp_cmd_t ctl;
    dp_sts_t sts;

    pbcs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    pbcs_dp #(
        .CFG_SIZE (CFG_SIZE)
    ) u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .sts         (sts),
        .cmd         (cmd),
        .func_num    (func_num),
        .reg_addr    (reg_addr),
        .io_port     (io_port),
        .wr_data     (wr_data),
        .done        (done),
        .rd_data     (rd_data),
        .smi_pulse   (smi_pulse),
        .route_valid (route_valid),
        .route_pin   (route_pin),
        .route_off   (route_off),
        .route_irq   (route_irq)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_smi_done: assert property (@(posedge clk) disable iff (!rst_n)
        done && smi_pulse |-> !route_valid && rd_data == 8'h00)
        else $error("smi pulse outside a clean result");

    a_route_off: assert property (@(posedge clk) disable iff (!rst_n)
        done && route_off |-> route_valid && route_irq == 4'd0)
        else $error("disabled route carries an irq");

endmodule

>>> hdl/pbcs_ctrl.sv
module pbcs_ctrl
    import pbcs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  dp_sts_t sts,
    output dp_cmd_t ctl,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:     state_next = ST_EXEC;
            ST_EXEC:     state_next = sts.smi_go ? ST_SMI_LOOK : ST_IDLE;
            ST_SMI_LOOK: state_next = ST_SMI_EXEC;
            ST_SMI_EXEC: state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.capture  = 1'b0;
        ctl.rd_sel   = RSEL_ITEM;
        ctl.exec     = 1'b0;
        ctl.smi_exec = 1'b0;
        busy         = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                busy        = 1'b0;
                ctl.capture = start;
            end
            ST_LOOK:     ctl.rd_sel = RSEL_ITEM;
            ST_EXEC:     ctl.exec = 1'b1;
            ST_SMI_LOOK: ctl.rd_sel = RSEL_SMI_REQ;
            ST_SMI_EXEC: ctl.smi_exec = 1'b1;
            default:     busy = 1'b1;
        endcase
    end

endmodule

>>> hdl/pbcs_dp.sv
module pbcs_dp
    import pbcs_pkg::*;
#(
    parameter int CFG_SIZE = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     ctl,
    output dp_sts_t     sts,
    input  logic [1:0]  cmd,
    input  logic [2:0]  func_num,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] io_port,
    input  logic [7:0]  wr_data,
    output logic        done,
    output logic [7:0]  rd_data,
    output logic        smi_pulse,
    output logic        route_valid,
    output logic [1:0]  route_pin,
    output logic        route_off,
    output logic [3:0]  route_irq
);

    localparam int AW = $clog2(CFG_SIZE);

    logic [1:0]  cmd_reg;
    logic [2:0]  func_reg;
    logic [7:0]  addr_reg;
    logic [15:0] port_reg;
    logic [7:0]  wdata_reg;
    logic [7:0]  apm_control_reg;
    logic [7:0]  apm_status_reg;

    logic [7:0]          cfg_mem [CFG_SIZE];
    logic [CFG_SIZE-1:0] valid_reg;
    logic [7:0]          mem_q_reg;
    logic                vld_q_reg;
    logic [7:0]          dflt_q_reg;

    logic        done_reg;
    logic [7:0]  rd_data_reg;
    logic        smi_reg;
    logic        rv_reg;
    logic [1:0]  rpin_reg;
    logic        roff_reg;
    logic [3:0]  rirq_reg;

    logic [7:0] rd_addr;
    logic [7:0] cur;
    logic       is_ctl;
    logic       is_sts;
    logic       writable;
    logic [7:0] wval;
    logic       rv;
    logic [1:0] rpin;
    logic       roff;
    logic [3:0] rirq;
    logic       wr_en;
    logic [7:0] wr_addr;
    logic [7:0] wr_val;
    logic       load;
    logic [7:0] rd_next;
    logic       smi_next;

    always_ff @(posedge clk)
    begin
        if (ctl.capture)
        begin
            cmd_reg   <= cmd;
            func_reg  <= func_num;
            addr_reg  <= reg_addr;
            port_reg  <= io_port;
            wdata_reg <= wr_data;
        end
    end

    // config byte lookup: smi request byte in the smi step, smi enable for any io write, else the item address
    always_comb
    begin
        if (ctl.rd_sel == RSEL_SMI_REQ)
        begin
            rd_addr = SMI_REQ_REG;
        end
        else if (cmd_reg == CMD_IO_WR)
        begin
            rd_addr = SMI_EN_REG;
        end
        else
        begin
            rd_addr = addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mem_q_reg  <= cfg_mem[rd_addr[AW-1:0]];
        vld_q_reg  <= valid_reg[rd_addr[AW-1:0]];
        dflt_q_reg <= reset_value(rd_addr);
        if (wr_en)
        begin
            cfg_mem[wr_addr[AW-1:0]] <= wr_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr[AW-1:0]] <= 1'b1;
        end
    end

    assign cur      = vld_q_reg ? mem_q_reg : dflt_q_reg;
    assign is_ctl   = (port_reg == APM_CTL_PORT);
    assign is_sts   = (port_reg == APM_STS_PORT);
    assign writable = (func_reg == 3'd0) && !is_read_only(addr_reg);

    always_comb
    begin
        sts.smi_go = (cmd_reg == CMD_IO_WR) && is_ctl && cur[7];
    end

    always_comb
    begin
        wval = wdata_reg;
        rv   = 1'b0;
        rpin = PIN_INTA;
        roff = 1'b0;
        rirq = 4'd0;
        case (addr_reg)
            REG_COMMAND_LO: wval = (wdata_reg & 8'h08) | 8'h07;
            REG_COMMAND_HI: wval = 8'h00;
            REG_STATUS_LO:  wval = 8'h00;
            REG_STATUS_HI:  wval = 8'h02;
            REG_ROUTE_A, REG_ROUTE_B, REG_ROUTE_C, REG_ROUTE_D:
            begin
                rv = 1'b1;
                case (addr_reg)
                    REG_ROUTE_A: rpin = PIN_INTA;
                    REG_ROUTE_C: rpin = PIN_INTC;
                    REG_ROUTE_B: rpin = PIN_INTB;
                    default:     rpin = PIN_INTD;
                endcase
                roff = wdata_reg[7];
                rirq = wdata_reg[7] ? 4'd0 : wdata_reg[3:0];
            end
            SMI_REQ_REG, REG_SMI_REQ_HI: wval = cur & wdata_reg;
            default: wval = wdata_reg;
        endcase
        if (!(cmd_reg == CMD_CFG_WR && writable))
        begin
            rv   = 1'b0;
            rpin = PIN_INTA;
            roff = 1'b0;
            rirq = 4'd0;
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_val  = wval;
        if (ctl.smi_exec)
        begin
            wr_en   = 1'b1;
            wr_addr = SMI_REQ_REG;
            wr_val  = cur | 8'h80;
        end
        else if (ctl.exec && cmd_reg == CMD_CFG_WR && writable)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            apm_control_reg <= 8'h00;
            apm_status_reg  <= 8'h00;
        end
        else if (ctl.exec && cmd_reg == CMD_IO_WR)
        begin
            if (is_ctl)
            begin
                apm_control_reg <= wdata_reg;
            end
            else if (is_sts)
            begin
                apm_status_reg <= wdata_reg;
            end
        end
    end

    always_comb
    begin
        rd_next = 8'h00;
        case (cmd_reg)
            CMD_CFG_RD: rd_next = (func_reg != 3'd0) ? ABSENT_BYTE : cur;
            CMD_IO_RD:
            begin
                if (is_ctl)
                begin
                    rd_next = apm_control_reg;
                end
                else if (is_sts)
                begin
                    rd_next = apm_status_reg;
                end
                else
                begin
                    rd_next = ABSENT_BYTE;
                end
            end
            default: rd_next = 8'h00;
        endcase
        if (ctl.smi_exec)
        begin
            rd_next = 8'h00;
        end
    end

    assign load     = (ctl.exec && !sts.smi_go) || ctl.smi_exec;
    assign smi_next = ctl.smi_exec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rd_data_reg <= rd_next;
            smi_reg     <= smi_next;
            rv_reg      <= rv && !ctl.smi_exec;
            rpin_reg    <= ctl.smi_exec ? PIN_INTA : rpin;
            roff_reg    <= roff && !ctl.smi_exec;
            rirq_reg    <= ctl.smi_exec ? 4'd0 : rirq;
        end
    end

    assign done        = done_reg;
    assign rd_data     = rd_data_reg;
    assign smi_pulse   = smi_reg;
    assign route_valid = rv_reg;
    assign route_pin   = rpin_reg;
    assign route_off   = roff_reg;
    assign route_irq   = rirq_reg;

endmodule
